FILE: design/assert_macros.svh
// Assertion macros of the interval assigner RTL, used by the datapath.
// Depends on nothing; NO_ASSERTIONS removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that cons holds in the same cycle whenever ante holds.
`define TRIA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define TRIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TRIA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define TRIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/tria_pkg.sv
// Shared constants and types of the two-resource interval assigner.
// Used by the channel interfaces, the controller and the datapath.
package tria_pkg;

  // Store depth and field widths.
  localparam int unsigned MaxAct = 64;
  localparam int unsigned IdxW   = $clog2(MaxAct);
  localparam int unsigned CntW   = $clog2(MaxAct + 1);
  localparam int unsigned MinW   = 11;
  localparam logic [MinW-1:0] DayMin = MinW'(1440);

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_RDI,
    ST_RK_KEY,
    ST_RK_SCAN,
    ST_RK_LAST,
    ST_RK_WR,
    ST_AS_RDO,
    ST_AS_RDA,
    ST_AS_EXE,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // Address source of the start-minute memory read port.
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_SCAN,
    RD_ORDER
  } start_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_en;
    logic       key_load;
    logic       scan;
    logic       order_wr;
    logic       assign_exe;
    logic       out_load;
    start_sel_e start_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_space;
  } status_t;

endpackage

FILE: design/tria_act_if.sv
// Input channel carrying one activity word per handshake.
// Depends on tria_pkg for the minute width.
interface tria_act_if;
  logic                      valid;
  logic                      ready;
  logic [tria_pkg::MinW-1:0] start_minute;
  logic [tria_pkg::MinW-1:0] end_minute;
  logic                      last_item;

  modport source (output valid, output start_minute, output end_minute,
                  output last_item, input ready);
  modport sink (input valid, input start_minute, input end_minute,
                input last_item, output ready);
endinterface

FILE: design/tria_res_if.sv
// Output channel carrying one assignment word per handshake.
// Depends on tria_pkg for the index width.
interface tria_res_if;
  logic                      valid;
  logic                      ready;
  logic [tria_pkg::IdxW-1:0] activity_index;
  logic                      to_second;
  logic                      impossible;
  logic                      overflow;
  logic                      last_result;

  modport source (output valid, output activity_index, output to_second,
                  output impossible, output overflow, output last_result,
                  input ready);
  modport sink (input valid, input activity_index, input to_second,
                input impossible, input overflow, input last_result,
                output ready);
endinterface

FILE: design/two_resource_interval_assigner_unit.sv
// Two-resource interval assigner, top level: controller plus datapath.
// Depends on tria_pkg, tria_act_if, tria_res_if, tria_ctrl and tria_dpath.
//
// Activities (start and end minute, end exclusive, minutes above 1440 are
// saturated) are taken one word per cycle until a word with last_item set
// arrives; words beyond 64 are dropped and flag overflow. The block then
// stable-sorts the n loaded activities by start, places them greedily onto
// two resources and returns one result word per activity in arrival order.
// After the last word, the rank sort makes one compare per cycle through the
// single read port of the start-minute memory; the placement walk then visits
// the activities in start order; results leave through an output register that
// holds each word until the sink takes it. No input word is taken from the last
// input word until the final result has been loaded into the output register.
module two_resource_interval_assigner_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tria_act_if.sink   act_i,
  tria_res_if.source res_o
);

  tria_pkg::cmd_t    cmd;
  tria_pkg::status_t sts;

  // Sequencer.
  tria_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Stores and arithmetic.
  tria_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .act_i  (act_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

FILE: design/tria_ctrl.sv
// Sequencer of the interval assigner: load, rank sort, assignment walk, output.
// Depends on tria_pkg for the state, command and status types.
module tria_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tria_pkg::status_t sts_i,
  output tria_pkg::cmd_t    cmd_o
);

  tria_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tria_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.start_sel = tria_pkg::RD_ITEM;
    unique case (state_q)
      tria_pkg::ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        if (sts_i.load_last) state_d = tria_pkg::ST_RK_RDI;
      end
      tria_pkg::ST_RK_RDI: begin
        cmd_o.start_sel = tria_pkg::RD_ITEM;
        state_d         = tria_pkg::ST_RK_KEY;
      end
      tria_pkg::ST_RK_KEY: begin
        cmd_o.key_load = 1'b1;
        state_d        = tria_pkg::ST_RK_SCAN;
      end
      tria_pkg::ST_RK_SCAN: begin
        cmd_o.start_sel = tria_pkg::RD_SCAN;
        cmd_o.scan      = 1'b1;
        if (sts_i.j_last) state_d = tria_pkg::ST_RK_LAST;
      end
      tria_pkg::ST_RK_LAST: begin
        state_d = tria_pkg::ST_RK_WR;
      end
      tria_pkg::ST_RK_WR: begin
        cmd_o.order_wr = 1'b1;
        state_d = sts_i.i_last ? tria_pkg::ST_AS_RDO : tria_pkg::ST_RK_RDI;
      end
      tria_pkg::ST_AS_RDO: begin
        state_d = tria_pkg::ST_AS_RDA;
      end
      tria_pkg::ST_AS_RDA: begin
        cmd_o.start_sel = tria_pkg::RD_ORDER;
        state_d         = tria_pkg::ST_AS_EXE;
      end
      tria_pkg::ST_AS_EXE: begin
        cmd_o.assign_exe = 1'b1;
        state_d = sts_i.k_last ? tria_pkg::ST_OUT_RD : tria_pkg::ST_AS_RDO;
      end
      tria_pkg::ST_OUT_RD: begin
        state_d = tria_pkg::ST_OUT_LD;
      end
      tria_pkg::ST_OUT_LD: begin
        if (sts_i.out_space) begin
          cmd_o.out_load = 1'b1;
          state_d = sts_i.k_last ? tria_pkg::ST_LOAD : tria_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_d = tria_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: design/tria_dpath.sv
// Datapath of the interval assigner: stores, counters, rank compare,
// busy-until tracking and the output register.
// Depends on tria_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module tria_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  tria_act_if.sink          act_i,
  tria_res_if.source        res_o,
  input  tria_pkg::cmd_t    cmd_i,
  output tria_pkg::status_t sts_o
);

  localparam int unsigned IdxW = tria_pkg::IdxW;
  localparam int unsigned CntW = tria_pkg::CntW;
  localparam int unsigned MinW = tria_pkg::MinW;
  localparam int unsigned MaxAct = tria_pkg::MaxAct;

  // Memories.
  logic [MinW-1:0] start_mem [MaxAct];
  logic [MinW-1:0] end_mem   [MaxAct];
  logic [IdxW-1:0] order_mem [MaxAct];
  logic            label_mem [MaxAct];

  logic [MinW-1:0] start_rd_q, end_rd_q;
  logic [IdxW-1:0] order_rd_q;
  logic            label_rd_q;

  // Control registers.
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] last_q, i_q, j_q, k_q, jp_q, rank_q;
  logic            pend_q, dropped_q, fail_q;
  logic [MinW-1:0] key_q, busy0_q, busy1_q;

  // Output register.
  logic            out_valid_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_lbl_q, out_imp_q, out_ovf_q, out_last_q;

  logic            accept, room, load_last, out_space;
  logic [CntW-1:0] count_next;
  logic [MinW-1:0] s_clamp, e_clamp, start_addr_val;
  logic [IdxW-1:0] start_addr;
  logic            hit;
  logic            nonempty, fit0, fit1, lbl, occ0, occ1, fail_now;

  // Input handshake and clamping of minutes to the day.
  assign act_i.ready = cmd_i.load_en;
  assign accept      = act_i.valid & cmd_i.load_en;
  assign room        = (count_q < CntW'(MaxAct));
  assign count_next  = room ? count_q + CntW'(1) : count_q;
  assign load_last   = accept & act_i.last_item;
  assign s_clamp = (act_i.start_minute > tria_pkg::DayMin) ? tria_pkg::DayMin
                                                             : act_i.start_minute;
  assign e_clamp = (act_i.end_minute > tria_pkg::DayMin) ? tria_pkg::DayMin
                                                           : act_i.end_minute;

  // Start memory read address.
  always_comb begin
    case (cmd_i.start_sel)
      tria_pkg::RD_ITEM:  start_addr = i_q;
      tria_pkg::RD_SCAN:  start_addr = j_q;
      tria_pkg::RD_ORDER: start_addr = order_rd_q;
      default:            start_addr = i_q;
    endcase
  end
  assign start_addr_val = start_rd_q;

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      start_mem[count_q[IdxW-1:0]] <= s_clamp;
      end_mem[count_q[IdxW-1:0]]   <= e_clamp;
    end
    if (cmd_i.order_wr) order_mem[rank_q] <= i_q;
    if (cmd_i.assign_exe) label_mem[order_rd_q] <= lbl;
    start_rd_q <= start_mem[start_addr];
    end_rd_q   <= end_mem[order_rd_q];
    order_rd_q <= order_mem[k_q];
    label_rd_q <= label_mem[k_q];
  end

  // Stable rank: earlier start, or equal start and earlier arrival.
  assign hit = (start_addr_val < key_q) || ((start_addr_val == key_q) && (jp_q < i_q));

  // Greedy placement of the current activity in start order.
  assign nonempty = (end_rd_q > start_rd_q);
  assign fit0     = !nonempty || (start_rd_q >= busy0_q);
  assign fit1     = !nonempty || (start_rd_q >= busy1_q);
  always_comb begin
    lbl      = 1'b0;
    occ0     = 1'b0;
    occ1     = 1'b0;
    fail_now = 1'b0;
    if (k_q == IdxW'(0)) begin
      occ0 = 1'b1;
    end else if (k_q == IdxW'(1)) begin
      lbl  = 1'b1;
      occ1 = 1'b1;
    end else if (fit0) begin
      occ0 = 1'b1;
    end else if (fit1) begin
      lbl  = 1'b1;
      occ1 = 1'b1;
    end else begin
      lbl      = 1'b1;
      fail_now = 1'b1;
    end
  end

  // Counters, flags and busy-until minutes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      last_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      jp_q      <= '0;
      rank_q    <= '0;
      pend_q    <= 1'b0;
      dropped_q <= 1'b0;
      fail_q    <= 1'b0;
      key_q     <= '0;
      busy0_q   <= '0;
      busy1_q   <= '0;
    end else begin
      pend_q <= cmd_i.scan;
      if (accept) begin
        count_q <= count_next;
        if (!room) dropped_q <= 1'b1;
        if (act_i.last_item) begin
          count_q <= '0;
          last_q  <= IdxW'(count_next - CntW'(1));
          i_q     <= '0;
          k_q     <= '0;
          fail_q  <= 1'b0;
          busy0_q <= '0;
          busy1_q <= '0;
        end
      end
      if (cmd_i.key_load) begin
        key_q  <= start_rd_q;
        rank_q <= '0;
        j_q    <= '0;
      end
      if (cmd_i.scan) begin
        jp_q <= j_q;
        j_q  <= j_q + IdxW'(1);
      end
      if (pend_q && hit) rank_q <= rank_q + IdxW'(1);
      if (cmd_i.order_wr) i_q <= i_q + IdxW'(1);
      if (cmd_i.assign_exe) begin
        k_q <= (k_q == last_q) ? '0 : k_q + IdxW'(1);
        if (fail_now) fail_q <= 1'b1;
        if (occ0 && nonempty && (end_rd_q > busy0_q)) busy0_q <= end_rd_q;
        if (occ1 && nonempty && (end_rd_q > busy1_q)) busy1_q <= end_rd_q;
      end
      if (cmd_i.out_load) begin
        k_q <= (k_q == last_q) ? '0 : k_q + IdxW'(1);
        if (k_q == last_q) dropped_q <= 1'b0;
      end
    end
  end

  // Output register: holds a word until the sink takes it.
  assign out_space = !out_valid_q || res_o.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= k_q;
      out_lbl_q  <= label_rd_q;
      out_imp_q  <= fail_q;
      out_ovf_q  <= dropped_q;
      out_last_q <= (k_q == last_q);
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.activity_index = out_idx_q;
  assign res_o.to_second      = out_lbl_q;
  assign res_o.impossible     = out_imp_q;
  assign res_o.overflow       = out_ovf_q;
  assign res_o.last_result    = out_last_q;

  // Status to the controller.
  assign sts_o.load_last = load_last;
  assign sts_o.j_last    = (j_q == last_q);
  assign sts_o.i_last    = (i_q == last_q);
  assign sts_o.k_last    = (k_q == last_q);
  assign sts_o.out_space = out_space;

  // Checks.
  `TRIA_ASSERT_IMPLY(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CntW'(MaxAct))
  `TRIA_ASSERT_IMPLY(a_out_room, clk_i, rst_ni, cmd_i.out_load, out_space)
  `TRIA_ASSERT_IMPLY(a_rank_range, clk_i, rst_ni, cmd_i.order_wr, rank_q <= last_q)
  `TRIA_ASSERT_NEXT(a_walk_clear, clk_i, rst_ni, load_last, (count_q == '0) && !fail_q && (busy0_q == '0) && (busy1_q == '0))

endmodule
